FILE: rtl/lr_pkg.sv
package lr_pkg;

  localparam int COORD_W   = 6;
  localparam int DATA_W    = 16;
  localparam int SIZE_W    = 7;
  localparam int ERR_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_DEPTH = 2;

  localparam logic [SIZE_W-1:0] SCREEN_SIZE_RESET = SIZE_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [DATA_W-1:0]  glyph;
    logic [DATA_W-1:0]  color;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [DATA_W-1:0]  cell_glyph;
    logic [DATA_W-1:0]  cell_color;
    logic               visible;
    logic               last;
  } cell_t;

  typedef struct packed {
    logic [COORD_W-1:0]      cur_x;
    logic [COORD_W-1:0]      cur_y;
    logic [COORD_W-1:0]      stop_coord;
    logic signed [ERR_W-1:0] err_term;
    logic signed [ERR_W-1:0] inc_keep;
    logic signed [ERR_W-1:0] inc_step;
    logic                    steep_mode;
    logic                    minor_step_up;
    logic [DATA_W-1:0]       held_glyph;
    logic [DATA_W-1:0]       held_color;
  } cmd_t;

endpackage

FILE: rtl/line_rasterizer.sv
// Bresenham line stepper for a character screen. Each request (two endpoints,
// glyph, color) yields one result per cell of the line, walked from the lower
// x end for shallow lines and the lower y end for steep ones, with a visible
// flag against the screen_width/screen_height registers and last on the final
// cell. Requests are classified in the cycle they are pushed and wait in a
// two-entry command queue. The stepper loads a request, then emits one cell per
// cycle when pop keeps up, and takes the next request only after the final
// cell of a line of n = 1 + max(|dx|,|dy|) cells (up to 64). Configuration
// writes are always taken (cfg_ready is high) and must happen while idle.
module line_rasterizer (
  input  logic                         clk,
  input  logic                         rst,
  input  lr_pkg::req_t                 req,
  input  logic                         push,
  output logic                         full,
  output lr_pkg::cell_t                result,
  output logic                         empty,
  input  logic                         pop,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lr_pkg::SIZE_W-1:0]    cfg_data
);
  import lr_pkg::*;

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  cmd_t              front_cmd;
  cmd_t              head_cmd;
  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_SIZE_RESET;
      screen_height <= SCREEN_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lr_front u_front (
    .req    (req),
    .push   (push),
    .q_full (q_full),
    .full   (full),
    .q_push (q_push),
    .cmd    (front_cmd)
  );

  lr_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (front_cmd),
    .rd      (q_pop),
    .rd_data (head_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  lr_stepper u_stepper (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .cmd           (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .result        (result)
  );

endmodule

FILE: rtl/lr_front.sv
module lr_front (
  input  lr_pkg::req_t req,
  input  logic         push,
  input  logic         q_full,
  output logic         full,
  output logic         q_push,
  output lr_pkg::cmd_t cmd
);
  import lr_pkg::*;

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] neg_dx;
  logic signed [COORD_W:0] neg_dy;
  logic [COORD_W-1:0]      abs_dx;
  logic [COORD_W-1:0]      abs_dy;
  logic                    steep;
  logic                    from_start;
  logic signed [ERR_W-1:0] two_dx;
  logic signed [ERR_W-1:0] two_dy;
  logic signed [ERR_W-1:0] one_dx;
  logic signed [ERR_W-1:0] one_dy;

  always_comb begin
    dx     = $signed({1'b0, req.end_x}) - $signed({1'b0, req.start_x});
    dy     = $signed({1'b0, req.end_y}) - $signed({1'b0, req.start_y});
    neg_dx = -dx;
    neg_dy = -dy;
    abs_dx = dx[COORD_W] ? neg_dx[COORD_W-1:0] : dx[COORD_W-1:0];
    abs_dy = dy[COORD_W] ? neg_dy[COORD_W-1:0] : dy[COORD_W-1:0];
    steep  = abs_dy > abs_dx;
    two_dx = $signed({2'b00, abs_dx, 1'b0});
    two_dy = $signed({2'b00, abs_dy, 1'b0});
    one_dx = $signed({3'b000, abs_dx});
    one_dy = $signed({3'b000, abs_dy});

    from_start = steep ? !dy[COORD_W] : !dx[COORD_W];

    cmd.cur_x         = from_start ? req.start_x : req.end_x;
    cmd.cur_y         = from_start ? req.start_y : req.end_y;
    cmd.steep_mode    = steep;
    cmd.minor_step_up = (dx[COORD_W] && dy[COORD_W]) ||
                        (dx != '0 && !dx[COORD_W] && dy != '0 && !dy[COORD_W]);
    cmd.held_glyph    = req.glyph;
    cmd.held_color    = req.color;
    if (steep) begin
      cmd.stop_coord = from_start ? req.end_y : req.start_y;
      cmd.err_term   = two_dx - one_dy;
      cmd.inc_keep   = two_dx;
      cmd.inc_step   = two_dx - two_dy;
    end else begin
      cmd.stop_coord = from_start ? req.end_x : req.start_x;
      cmd.err_term   = two_dy - one_dx;
      cmd.inc_keep   = two_dy;
      cmd.inc_step   = two_dy - two_dx;
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

endmodule

FILE: rtl/lr_cmd_queue.sv
module lr_cmd_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  lr_pkg::cmd_t wr_data,
  input  logic         rd,
  output lr_pkg::cmd_t rd_data,
  output logic         q_full,
  output logic         q_empty
);
  import lr_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             entries [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = count == CNT_W'(CMD_DEPTH);
  assign q_empty = count == '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/lr_stepper.sv
module lr_stepper (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lr_pkg::SIZE_W-1:0] screen_width,
  input  logic [lr_pkg::SIZE_W-1:0] screen_height,
  input  lr_pkg::cmd_t              cmd,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output lr_pkg::cell_t             result
);
  import lr_pkg::*;

  cmd_t               st;
  logic               busy;
  logic               out_valid;
  cell_t              out_cell;
  logic [COORD_W-1:0] major;
  logic               at_stop;
  logic               take_step;
  logic               emit_ok;
  logic [COORD_W-1:0] minor;
  logic [COORD_W-1:0] minor_next;
  cell_t              cur_cell;

  always_comb begin
    major      = st.steep_mode ? st.cur_y : st.cur_x;
    minor      = st.steep_mode ? st.cur_x : st.cur_y;
    at_stop    = major >= st.stop_coord;
    take_step  = st.steep_mode ? (st.err_term > 0) : !st.err_term[ERR_W-1];
    minor_next = st.minor_step_up ? minor + 1'b1 : minor - 1'b1;
    emit_ok    = busy && (!out_valid || pop);
    q_pop      = !busy && !q_empty;

    cur_cell.cell_x     = st.cur_x;
    cur_cell.cell_y     = st.cur_y;
    cur_cell.cell_glyph = st.held_glyph;
    cur_cell.cell_color = st.held_color;
    cur_cell.visible    = ({1'b0, st.cur_x} < screen_width) &&
                          ({1'b0, st.cur_y} < screen_height);
    cur_cell.last       = at_stop;
  end

  assign empty  = !out_valid;
  assign result = out_cell;

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      out_cell <= cur_cell;
    end
    if (q_pop) begin
      st <= cmd;
    end else if (emit_ok && !at_stop) begin
      if (st.steep_mode) begin
        st.cur_y <= st.cur_y + 1'b1;
        if (take_step) begin
          st.cur_x <= minor_next;
        end
      end else begin
        st.cur_x <= st.cur_x + 1'b1;
        if (take_step) begin
          st.cur_y <= minor_next;
        end
      end
      st.err_term <= st.err_term + (take_step ? st.inc_step : st.inc_keep);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_ok) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit_ok && at_stop) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
